// ===== rtl/til_pkg.sv =====
// Shared constants and control bundles for the trilinear interpolation unit.
// Used by til_lane, til_merge and trilinear_interpolation_unit; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package til_pkg;

  // Eight corners of a voxel cell, three axes.
  localparam int CORNER_COUNT = 8;
  localparam int AXIS_COUNT   = 3;

  // Register stages in each lane and in the merging tree.
  localparam int LANE_STAGES  = 4;
  localparam int MERGE_STAGES = 3;
  localparam int PIPE_STAGES  = LANE_STAGES + MERGE_STAGES;

  // Load enables for the four lane stages.
  typedef struct packed {
    logic en_weight;
    logic en_scale;
    logic en_split;
    logic en_join;
  } til_lane_ctrl_t;

  // Load enables for the three merge stages.
  typedef struct packed {
    logic en_pair;
    logic en_quad;
    logic en_final;
  } til_merge_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/til_lane.sv =====
// One corner lane: builds the corner weight and multiplies it by the sample.
// Depends on til_pkg for the lane control bundle.
`timescale 1ns / 1ps
`default_nettype none

module til_lane #(
  parameter int SAMPLE_WIDTH  = 24,
  parameter int FRACTION_BITS = 16,
  localparam int FRAC_W = FRACTION_BITS + 1,
  localparam int WXY_W  = 2 * FRACTION_BITS + 1,
  localparam int WGT_W  = 3 * FRACTION_BITS + 1,
  localparam int ACC_W  = SAMPLE_WIDTH + WGT_W
) (
  input  wire                              clk_i,
  input  wire til_pkg::til_lane_ctrl_t     ctrl_i,
  input  wire        [SAMPLE_WIDTH-1:0]    corner_i,
  input  wire        [FRAC_W-1:0]          gx_i,
  input  wire        [FRAC_W-1:0]          gy_i,
  input  wire        [FRAC_W-1:0]          gz_i,
  output logic signed [ACC_W-1:0]          product_o
);

  // The weight is split into a low and a high part so that each multiplier
  // takes only about half of the weight bits (WL_W low, WH_W high).
  localparam int WL_W = (WGT_W + 1) / 2;
  localparam int WH_W = WGT_W - WL_W;
  localparam int PL_W = SAMPLE_WIDTH + WL_W + 1;
  localparam int PH_W = SAMPLE_WIDTH + WH_W + 1;

  logic        [2*FRAC_W-1:0]     wxy_full;
  logic        [WXY_W-1:0]        wxy_d, wxy_q;
  logic        [FRAC_W-1:0]       gz_q;
  logic signed [SAMPLE_WIDTH-1:0] corner_s1_q, corner_s2_q;
  logic        [WXY_W+FRAC_W-1:0] wgt_full;
  logic        [WGT_W-1:0]        wgt_d, wgt_q;
  logic signed [PL_W-1:0]         pl_d, pl_q;
  logic signed [PH_W-1:0]         ph_d, ph_q;
  logic signed [ACC_W-1:0]        product_d, product_q;

  // Weight build: x and y factors first, then the z factor. Factors are at
  // most one in Q.FRACTION_BITS, so products never exceed one; top bits zero.
  assign wxy_full = gx_i * gy_i;
  assign wxy_d    = wxy_full[WXY_W-1:0];
  assign wgt_full = wxy_q * gz_q;
  assign wgt_d    = wgt_full[WGT_W-1:0];

  // Partial products of the signed sample with both weight halves.
  assign pl_d = corner_s2_q * $signed({1'b0, wgt_q[WL_W-1:0]});
  assign ph_d = corner_s2_q * $signed({1'b0, wgt_q[WGT_W-1:WL_W]});

  // Recombine the halves into the full weighted sample.
  assign product_d = (ACC_W'(ph_q) <<< WL_W) + ACC_W'(pl_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_weight) begin
      wxy_q       <= wxy_d;
      gz_q        <= gz_i;
      corner_s1_q <= $signed(corner_i);
    end
    if (ctrl_i.en_scale) begin
      wgt_q       <= wgt_d;
      corner_s2_q <= corner_s1_q;
    end
    if (ctrl_i.en_split) begin
      pl_q <= pl_d;
      ph_q <= ph_d;
    end
    if (ctrl_i.en_join) begin
      product_q <= product_d;
    end
  end

  assign product_o = product_q;

endmodule

`default_nettype wire

// ===== rtl/til_merge.sv =====
// Merging stage: registered adder tree over the eight lane products and rounding.
// Depends on til_pkg for the corner count and the merge control bundle.
`timescale 1ns / 1ps
`default_nettype none

module til_merge #(
  parameter int SAMPLE_WIDTH  = 24,
  parameter int FRACTION_BITS = 16,
  localparam int WGT_W = 3 * FRACTION_BITS + 1,
  localparam int ACC_W = SAMPLE_WIDTH + WGT_W
) (
  input  wire                                          clk_i,
  input  wire til_pkg::til_merge_ctrl_t                ctrl_i,
  input  wire [til_pkg::CORNER_COUNT-1:0][ACC_W-1:0]   products_i,
  output logic [SAMPLE_WIDTH-1:0]                      blended_o
);

  localparam int PAIR_COUNT = til_pkg::CORNER_COUNT / 2;
  localparam int QUAD_COUNT = til_pkg::CORNER_COUNT / 4;
  localparam int SHIFT      = 3 * FRACTION_BITS;
  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (SHIFT - 1);

  // Weights are nonnegative and sum to one, so no partial sum overflows ACC_W.
  logic [PAIR_COUNT-1:0][ACC_W-1:0] pair_d, pair_q;
  logic [QUAD_COUNT-1:0][ACC_W-1:0] quad_d, quad_q;
  logic [ACC_W-1:0]                 total;
  logic [SAMPLE_WIDTH-1:0]          blended_d, blended_q;

  // First level of the tree.
  always_comb begin
    for (int p = 0; p < PAIR_COUNT; p++) begin
      pair_d[p] = products_i[2*p] + products_i[2*p+1];
    end
  end

  // Second level of the tree.
  always_comb begin
    for (int q = 0; q < QUAD_COUNT; q++) begin
      quad_d[q] = pair_q[2*q] + pair_q[2*q+1];
    end
  end

  // Final sum plus one half, then floor by dropping the fraction bits.
  assign total     = quad_q[0] + quad_q[1] + HALF;
  assign blended_d = total[SHIFT +: SAMPLE_WIDTH];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_pair) begin
      pair_q <= pair_d;
    end
    if (ctrl_i.en_quad) begin
      quad_q <= quad_d;
    end
    if (ctrl_i.en_final) begin
      blended_q <= blended_d;
    end
  end

  assign blended_o = blended_q;

endmodule

`default_nettype wire

// ===== rtl/trilinear_interpolation_unit.sv =====
// Throughput: one beat per cycle while the output is not stalled, set by the
// four-stage multiplier lanes and the three-stage adder tree, each of which
// takes a new item every cycle unless its stage is held.
// Each stage holds its item while the next stage is full and not loading, so the
// unit keeps taking input while a result waits on the output, until all are full.
// Reset clears the stage valid flags only; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module trilinear_interpolation_unit #(
  parameter int SAMPLE_WIDTH  = 24,
  parameter int FRACTION_BITS = 16,
  localparam int FRAC_W     = FRACTION_BITS + 1,
  localparam int FIELDS_W   = til_pkg::CORNER_COUNT * SAMPLE_WIDTH
                              + til_pkg::AXIS_COUNT * FRAC_W,
  localparam int IN_DATA_W  = ((FIELDS_W + 7) / 8) * 8,
  localparam int OUT_DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  // Input beat.
  input  wire                   s_axis_tvalid,
  output logic                  s_axis_tready,
  // Fields from bit 0: corner_0 .. corner_7, frac_x, frac_y, frac_z, zero pad.
  input  wire  [IN_DATA_W-1:0]  s_axis_tdata,
  // Output beat.
  output logic                  m_axis_tvalid,
  input  wire                   m_axis_tready,
  // Fields from bit 0: blended_value, zero pad.
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int WGT_W    = 3 * FRACTION_BITS + 1;
  localparam int ACC_W    = SAMPLE_WIDTH + WGT_W;
  localparam int FRAC_LSB = til_pkg::CORNER_COUNT * SAMPLE_WIDTH;
  localparam logic [FRAC_W-1:0] ONE = FRAC_W'(1) << FRACTION_BITS;

  logic [FRAC_W-1:0] frac_raw [til_pkg::AXIS_COUNT];
  logic [FRAC_W-1:0] frac_c   [til_pkg::AXIS_COUNT];
  logic [FRAC_W-1:0] frac_n   [til_pkg::AXIS_COUNT];

  logic [til_pkg::PIPE_STAGES:1] valid_d, valid_q;
  logic [til_pkg::PIPE_STAGES:1] stage_en;
  logic [til_pkg::PIPE_STAGES:1] valid_in;

  til_pkg::til_lane_ctrl_t  lane_ctrl;
  til_pkg::til_merge_ctrl_t merge_ctrl;

  logic [til_pkg::CORNER_COUNT-1:0][ACC_W-1:0] products;
  logic [SAMPLE_WIDTH-1:0]                     blended;

  // Clamp each fraction to one and form its complement.
  always_comb begin
    for (int a = 0; a < til_pkg::AXIS_COUNT; a++) begin
      frac_raw[a] = s_axis_tdata[FRAC_LSB + a*FRAC_W +: FRAC_W];
      frac_c[a]   = (frac_raw[a] > ONE) ? ONE : frac_raw[a];
      frac_n[a]   = ONE - frac_c[a];
    end
  end

  // Per-stage load enables: a stage loads when it is empty or its
  // successor loads in the same cycle.
  always_comb begin
    stage_en[til_pkg::PIPE_STAGES] = !valid_q[til_pkg::PIPE_STAGES] || m_axis_tready;
    for (int k = til_pkg::PIPE_STAGES - 1; k >= 1; k--) begin
      stage_en[k] = !valid_q[k] || stage_en[k+1];
    end
  end

  // Valid flags move forward with the enables.
  assign valid_in = {valid_q[til_pkg::PIPE_STAGES-1:1], s_axis_tvalid};

  always_comb begin
    for (int k = 1; k <= til_pkg::PIPE_STAGES; k++) begin
      valid_d[k] = stage_en[k] ? valid_in[k] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Map stage enables onto the lane and merge bundles.
  assign lane_ctrl.en_weight = stage_en[1];
  assign lane_ctrl.en_scale  = stage_en[2];
  assign lane_ctrl.en_split  = stage_en[3];
  assign lane_ctrl.en_join   = stage_en[4];
  assign merge_ctrl.en_pair  = stage_en[5];
  assign merge_ctrl.en_quad  = stage_en[6];
  assign merge_ctrl.en_final = stage_en[7];

  // One lane per corner; corner bits pick fraction or complement per axis.
  for (genvar j = 0; j < til_pkg::CORNER_COUNT; j++) begin : g_lane
    logic [FRAC_W-1:0] gx, gy, gz;

    assign gx = ((j & 1) != 0) ? frac_c[0] : frac_n[0];
    assign gy = ((j & 2) != 0) ? frac_c[1] : frac_n[1];
    assign gz = ((j & 4) != 0) ? frac_c[2] : frac_n[2];

    til_lane #(
      .SAMPLE_WIDTH  (SAMPLE_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
    ) u_lane (
      .clk_i     (clk_i),
      .ctrl_i    (lane_ctrl),
      .corner_i  (s_axis_tdata[j*SAMPLE_WIDTH +: SAMPLE_WIDTH]),
      .gx_i      (gx),
      .gy_i      (gy),
      .gz_i      (gz),
      .product_o (products[j])
    );
  end

  // Sum the lanes and round.
  til_merge #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_merge (
    .clk_i      (clk_i),
    .ctrl_i     (merge_ctrl),
    .products_i (products),
    .blended_o  (blended)
  );

  assign s_axis_tready = stage_en[1];
  assign m_axis_tvalid = valid_q[til_pkg::PIPE_STAGES];
  assign m_axis_tdata  = OUT_DATA_W'(blended);

endmodule

`default_nettype wire

// ===== dv/tb_trilinear_interpolation_unit.sv =====
// Self-checking testbench for trilinear_interpolation_unit: blends of voxel cells are
// predicted in the bench and compared beat by beat with the output stream.
// Depends on rtl/til_pkg.sv and rtl/trilinear_interpolation_unit.sv.
`timescale 1ns / 1ps

module tb_trilinear_interpolation_unit;

  localparam int SAMPLE_W   = 24;
  localparam int FRAC_BITS  = 16;
  localparam int FRAC_W     = FRAC_BITS + 1;
  localparam int IN_W       = 248;
  localparam int OUT_W      = 24;
  localparam int HOLD_LEN   = 300;
  localparam int IDLE_LIMIT = 5000;

  localparam logic [FRAC_W-1:0]   FRAC_ONE  = 17'd65536;
  localparam logic [SAMPLE_W-1:0] S_MAX     = 24'h7FFFFF;
  localparam logic [SAMPLE_W-1:0] S_MIN     = 24'h800000;
  localparam logic signed [95:0]  ROUND_HALF = 96'sd1 <<< (3 * FRAC_BITS - 1);

  // One voxel cell as it sits in tdata: corners in the low bits, then frac_x/y/z.
  typedef struct packed {
    logic [til_pkg::AXIS_COUNT-1:0][FRAC_W-1:0]     frac;
    logic [til_pkg::CORNER_COUNT-1:0][SAMPLE_W-1:0] corner;
  } voxel_cell_t;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;

  // Expected blends, oldest first.
  logic [SAMPLE_W-1:0] blend_q [$];
  int mismatch_count = 0;

  // Sender and receiver pacing knobs and state, set by the test sequence and some tests.
  int tx_gap_max   = 0;
  int tx_burst_left = 1;
  int rx_stall_pct = 0;
  int hold_requests = 0;
  int holds_seen    = 0;
  int hold_left     = 0;
  int stall_left    = 0;
  int idle_cycles   = 0;

  trilinear_interpolation_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock with a 2 ns period.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Blend the eight corners with weights built from clamped fractions and their
  // complements; the exact sum is rounded to nearest, ties toward plus infinity.
  function automatic logic [SAMPLE_W-1:0] trilinear_blend(input voxel_cell_t vox);
    logic [FRAC_W-1:0] near_w [til_pkg::AXIS_COUNT];
    logic [FRAC_W-1:0] far_w  [til_pkg::AXIS_COUNT];
    logic signed [95:0] acc;
    logic signed [95:0] wgt;
    logic signed [95:0] sample;
    logic [2:0] sel;
    acc = '0;
    for (int a = 0; a < til_pkg::AXIS_COUNT; a++) begin
      far_w[a]  = (vox.frac[a] > FRAC_ONE) ? FRAC_ONE : vox.frac[a];
      near_w[a] = FRAC_ONE - far_w[a];
    end
    for (int j = 0; j < til_pkg::CORNER_COUNT; j++) begin
      sel = 3'(j);
      wgt = (sel[0] ? far_w[0] : near_w[0]) * (sel[1] ? far_w[1] : near_w[1])
            * (sel[2] ? far_w[2] : near_w[2]);
      sample = $signed(vox.corner[j]);
      acc = acc + wgt * sample;
    end
    acc = (acc + ROUND_HALF) >>> (3 * FRAC_BITS);
    return acc[SAMPLE_W-1:0];
  endfunction

  // Drive one cell and hold it until it is taken; then maybe open a gap.
  // Called and left at a falling edge.
  task automatic send_cell(input voxel_cell_t vox);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = IN_W'(vox);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    blend_q.push_back(trilinear_blend(vox));
    @(negedge clk_i);
    if (tx_gap_max > 0) begin
      tx_burst_left--;
      if (tx_burst_left <= 0) begin
        s_axis_tvalid = 1'b0;
        repeat ($urandom_range(tx_gap_max, 1)) @(negedge clk_i);
        tx_burst_left = $urandom_range(12, 1);
      end
    end
  endtask

  task automatic stop_sending();
    s_axis_tvalid = 1'b0;
  endtask

  // Sender pause until every expected blend has come back.
  task automatic wait_drained();
    stop_sending();
    while (blend_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic voxel_cell_t flat_cell(input logic [SAMPLE_W-1:0] value,
                                           input logic [FRAC_W-1:0] fx,
                                           input logic [FRAC_W-1:0] fy,
                                           input logic [FRAC_W-1:0] fz);
    voxel_cell_t vox;
    for (int j = 0; j < til_pkg::CORNER_COUNT; j++) vox.corner[j] = value;
    vox.frac[0] = fx;
    vox.frac[1] = fy;
    vox.frac[2] = fz;
    return vox;
  endfunction

  function automatic logic [FRAC_W-1:0] random_frac();
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 60) return FRAC_W'($urandom_range(65536, 0));
    if (pick < 80) begin
      case ($urandom_range(6, 0))
        0: return 17'd0;
        1: return 17'd1;
        2: return 17'd32768;
        3: return 17'd65535;
        4: return FRAC_ONE;
        5: return 17'd65537;
        default: return 17'h1FFFF;
      endcase
    end
    return FRAC_W'($urandom());
  endfunction

  // Corners are full range, clustered around a base value, or edge values.
  function automatic voxel_cell_t random_cell();
    voxel_cell_t vox;
    int style;
    logic [SAMPLE_W-1:0] base;
    style = $urandom_range(9, 0);
    base  = SAMPLE_W'($urandom());
    for (int j = 0; j < til_pkg::CORNER_COUNT; j++) begin
      if (style < 5) begin
        vox.corner[j] = SAMPLE_W'($urandom());
      end else if (style < 8) begin
        vox.corner[j] = base + SAMPLE_W'($urandom_range(64, 0)) - 24'd32;
      end else begin
        case ($urandom_range(4, 0))
          0: vox.corner[j] = S_MAX;
          1: vox.corner[j] = S_MIN;
          2: vox.corner[j] = '0;
          3: vox.corner[j] = '1;
          default: vox.corner[j] = 24'd1;
        endcase
      end
    end
    for (int a = 0; a < til_pkg::AXIS_COUNT; a++) vox.frac[a] = random_frac();
    return vox;
  endfunction

  // Full-scale corners, a halfway blend in x, and each corner picked alone by fractions at zero or one.
  task automatic test_corner_extremes();
    voxel_cell_t vox;
    send_cell(flat_cell(S_MAX, '0, '0, '0));
    send_cell(flat_cell(S_MIN, FRAC_ONE, FRAC_ONE, FRAC_ONE));
    vox = flat_cell(S_MIN, 17'd32768, 17'd0, 17'd0);
    for (int j = 1; j < til_pkg::CORNER_COUNT; j += 2) vox.corner[j] = S_MAX;
    send_cell(vox);
    for (int j = 0; j < til_pkg::CORNER_COUNT; j++) begin
      vox = flat_cell(S_MIN, j[0] ? FRAC_ONE : '0, j[1] ? FRAC_ONE : '0,
                      j[2] ? FRAC_ONE : '0);
      vox.corner[j] = S_MAX;
      send_cell(vox);
    end
  endtask

  // Fractions at, just below and above one; above one must act as exactly one.
  task automatic test_fraction_clamp();
    voxel_cell_t vox;
    vox = flat_cell(S_MIN, 17'd65537, 17'd0, 17'd0);
    vox.corner[1] = S_MAX;
    send_cell(vox);
    vox = random_cell();
    vox.frac[0] = 17'h1FFFF;
    vox.frac[1] = 17'h1FFFF;
    vox.frac[2] = 17'h1FFFF;
    vox.corner[7] = 24'd123456;
    send_cell(vox);
    vox = flat_cell(S_MIN, 17'd65535, 17'd65535, 17'd65535);
    vox.corner[7] = S_MAX;
    send_cell(vox);
    vox = random_cell();
    vox.frac[0] = FRAC_ONE;
    vox.frac[1] = 17'h10000 | 17'h0AAAA;
    vox.frac[2] = 17'h15555;
    send_cell(vox);
  endtask

  // Exact halves round up, toward plus infinity, for both signs.
  task automatic test_rounding_ties();
    voxel_cell_t vox;
    vox = flat_cell('0, 17'd32768, '0, '0);
    vox.corner[1] = 24'd1;
    send_cell(vox);
    vox.corner[1] = '1;
    send_cell(vox);
    vox.corner[1] = 24'd3;
    send_cell(vox);
    vox.corner[1] = -24'sd3;
    send_cell(vox);
    vox = flat_cell('0, 17'd32768, 17'd32768, 17'd32768);
    vox.corner[7] = 24'd4;
    send_cell(vox);
    vox.corner[7] = -24'sd4;
    send_cell(vox);
  endtask

  // Random cells under random idling on both sides, then a stretch without any.
  task automatic test_random_cells(input int count);
    tx_gap_max   = 6;
    rx_stall_pct = 30;
    for (int i = 0; i < count; i++) begin
      if (i == count * 3 / 4) begin
        tx_gap_max   = 0;
        rx_stall_pct = 0;
      end
      send_cell(random_cell());
    end
  endtask

  // The receiver holds off for a long stretch while cells keep coming.
  task automatic test_output_hold_off(input int count);
    tx_gap_max = 0;
    rx_stall_pct = 10;
    hold_requests++;
    for (int i = 0; i < count; i++) send_cell(random_cell());
  endtask

  // Sender stops until the unit is empty, then restarts.
  task automatic test_drain_pause(input int count);
    tx_gap_max = 3;
    rx_stall_pct = 20;
    for (int i = 0; i < count; i++) send_cell(random_cell());
    wait_drained();
    for (int i = 0; i < count; i++) send_cell(random_cell());
  endtask

  // Receiver: a long hold-off on request, else short random stall runs.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        hold_left  = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready = 1'b0;
      end else if (rx_stall_pct > 0 && $urandom_range(99, 0) < rx_stall_pct) begin
        stall_left = $urandom_range(3, 0);
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // Compare each output beat with the oldest expected blend.
  always @(posedge clk_i) begin
    logic [SAMPLE_W-1:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (blend_q.size() == 0) begin
        $error("blended_value: unexpected beat %0d", $signed(m_axis_tdata[SAMPLE_W-1:0]));
        mismatch_count++;
      end else begin
        want = blend_q.pop_front();
        if (m_axis_tdata[SAMPLE_W-1:0] !== want) begin
          $error("blended_value expected %0d got %0d", $signed(want),
                 $signed(m_axis_tdata[SAMPLE_W-1:0]));
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    tx_gap_max   = 2;
    rx_stall_pct = 15;
    test_corner_extremes();
    test_fraction_clamp();
    test_rounding_ties();
    test_random_cells(900);
    test_output_hold_off(60);
    test_drain_pause(70);

    wait_drained();
    repeat (2 * til_pkg::PIPE_STAGES + 4) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
